@@ design/mfsc_pkg.sv @@
// shared constants and control types of the masked f1 score counter
`default_nettype none

package mfsc_pkg;

   localparam int PX_W   = 8;
   localparam int CNT_W  = 21;
   localparam int F1_W   = 17;
   localparam int DEN_W  = CNT_W + 2;
   localparam int REM_W  = DEN_W + 1;
   localparam int STEP_W = 5;

   localparam logic [PX_W-1:0]   GRAY_POS = 8'd0;
   localparam logic [PX_W-1:0]   GRAY_NEG = 8'd255;
   localparam logic [CNT_W-1:0]  CNT_CAP  = 21'd1048576;
   localparam logic [STEP_W-1:0] DIV_LAST = 5'd16;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 88;

   typedef struct packed {
      logic count_en;
      logic frame_end;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ design/mfsc_ctrl.sv @@
// controller state machine: pixel counting, division steps and result hand-off
`default_nettype none

module mfsc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic                req_tlast,
   output logic                     req_tready,
   input  wire mfsc_pkg::status_type status,
   output mfsc_pkg::cmd_type        cmd
);
   import mfsc_pkg::*;

   localparam logic [1:0] S_COUNT  = 2'd0;
   localparam logic [1:0] S_DIVIDE = 2'd1;
   localparam logic [1:0] S_HOLD   = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_COUNT: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.count_en = 1'b1;
               if (req_tlast) begin
                  cmd.frame_end = 1'b1;
                  step_in       = '0;
                  state_in      = S_DIVIDE;
               end
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_COUNT;
            end
         end
         default: begin
            state_in = S_COUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COUNT;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

@@ design/mfsc_datapath.sv @@
// datapath: saturating counters, frame snapshot, restoring divider, output register
`default_nettype none

module mfsc_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [7:0]          mask_px,
   input  wire logic [7:0]          predicted_px,
   input  wire logic [7:0]          target_px,
   input  wire logic [7:0]          individual_index,
   input  wire mfsc_pkg::cmd_type   cmd,
   output mfsc_pkg::status_type     status,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output logic [7:0]               scored_index,
   output logic [20:0]              true_pos,
   output logic [20:0]              false_pos,
   output logic [20:0]              false_neg,
   output logic [16:0]              f1_value
);
   import mfsc_pkg::*;

   logic [CNT_W-1:0] tp_ff, fp_ff, fn_ff;
   logic [CNT_W-1:0] tp_in, fp_in, fn_in;
   logic [CNT_W-1:0] tp_cl, fp_cl, fn_cl;
   logic             hit_tp, hit_fp, hit_fn, px_on;

   logic [CNT_W-1:0] tp_snap_ff, fp_snap_ff, fn_snap_ff;
   logic [PX_W-1:0]  idx_snap_ff;
   logic [DEN_W-1:0] den_ff;
   logic [REM_W-1:0] rem_ff;
   logic [F1_W-1:0]  quot_ff;
   logic [REM_W-1:0] rem_shift;
   logic [REM_W:0]   rem_diff;

   logic             out_valid_ff;

   assign px_on  = (mask_px != '0);
   assign hit_tp = px_on && (predicted_px == GRAY_POS) && (target_px == GRAY_POS);
   assign hit_fp = px_on && (predicted_px == GRAY_POS) && (target_px == GRAY_NEG);
   assign hit_fn = px_on && (predicted_px == GRAY_NEG) && (target_px == GRAY_POS);

   assign tp_in = (cmd.count_en && hit_tp && (tp_ff < CNT_CAP)) ? tp_ff + 1'b1 : tp_ff;
   assign fp_in = (cmd.count_en && hit_fp && (fp_ff < CNT_CAP)) ? fp_ff + 1'b1 : fp_ff;
   assign fn_in = (cmd.count_en && hit_fn && (fn_ff < CNT_CAP)) ? fn_ff + 1'b1 : fn_ff;

   // zero counts raised to one
   assign tp_cl = (tp_in == '0) ? CNT_W'(1) : tp_in;
   assign fp_cl = (fp_in == '0) ? CNT_W'(1) : fp_in;
   assign fn_cl = (fn_in == '0) ? CNT_W'(1) : fn_in;

   assign rem_shift = {rem_ff[REM_W-2:0], 1'b0};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         tp_ff <= '0;
         fp_ff <= '0;
         fn_ff <= '0;
      end else if (cmd.frame_end) begin
         tp_ff <= '0;
         fp_ff <= '0;
         fn_ff <= '0;
      end else begin
         tp_ff <= tp_in;
         fp_ff <= fp_in;
         fn_ff <= fn_in;
      end
   end

   // numerator is 2*tp*2^16, so the partial remainder starts at tp
   always_ff @(posedge clock) begin
      if (cmd.frame_end) begin
         tp_snap_ff  <= tp_cl;
         fp_snap_ff  <= fp_cl;
         fn_snap_ff  <= fn_cl;
         idx_snap_ff <= individual_index;
         den_ff      <= DEN_W'({tp_cl, 1'b0}) + DEN_W'(fp_cl) + DEN_W'(fn_cl);
         rem_ff      <= REM_W'(tp_cl);
         quot_ff     <= '0;
      end else if (cmd.div_step) begin
         if (!rem_diff[REM_W]) begin
            rem_ff <= rem_diff[REM_W-1:0];
         end else begin
            rem_ff <= rem_shift;
         end
         quot_ff <= {quot_ff[F1_W-2:0], ~rem_diff[REM_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         scored_index <= idx_snap_ff;
         true_pos     <= tp_snap_ff;
         false_pos    <= fp_snap_ff;
         false_neg    <= fn_snap_ff;
         f1_value     <= quot_ff;
      end
   end

   assign rsp_tvalid      = out_valid_ff;
   assign status.out_free = !out_valid_ff || rsp_tready;

endmodule

`default_nettype wire

@@ design/masked_f1_score_counter_unit.sv @@
// top level of the masked f1 score counter
//
// pixels arrive on the req_ stream, one word per cycle, as mask, predicted and
// target gray bytes plus the candidate index; tlast marks the final pixel.
// masked pixels with value 0 (positive) and 255 (negative) feed saturating
// true positive, false positive and false negative counters.
// the last pixel is counted, the counts are snapshot (zero raised to one) and
// cleared, and a restoring divider forms the q1.16 f1 score one bit a cycle.
// throughput: one pixel per cycle inside a frame; after the last pixel the
// input stalls through the 17 divider steps and the load into the output
// register, which waits while a previous result still occupies that register.
// the result word is valid on rsp_ once the hold state has loaded it.
// the output register keeps the result while the receiver stalls, and the next
// frame streams in meanwhile; only a second result waits for the register.
// reset clears the counters, the controller and the output valid flag.
`default_nettype none

module masked_f1_score_counter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // mask_px, predicted_px, target_px, individual_index
   input  wire logic [31:0] req_tdata,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // scored_index, true_pos, false_pos, false_neg, f1_value
   output logic [87:0]      rsp_tdata
);
   import mfsc_pkg::*;

   cmd_type    cmd;
   status_type status;

   logic [7:0]  scored_index;
   logic [20:0] true_pos, false_pos, false_neg;
   logic [16:0] f1_value;

   mfsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mfsc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .mask_px          (req_tdata[7:0]),
      .predicted_px     (req_tdata[15:8]),
      .target_px        (req_tdata[23:16]),
      .individual_index (req_tdata[31:24]),
      .cmd              (cmd),
      .status           (status),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .scored_index     (scored_index),
      .true_pos         (true_pos),
      .false_pos        (false_pos),
      .false_neg        (false_neg),
      .f1_value         (f1_value)
   );

   assign rsp_tdata = {f1_value, false_neg, false_pos, true_pos, scored_index};

   a_busy_after_frame: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken right after a frame end");

   a_f1_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> f1_value <= 17'd65536)
      else $error("f1 score above one");

   a_counts_raised: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (true_pos != '0) && (false_pos != '0) && (false_neg != '0))
      else $error("zero count in result");

   a_counts_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (true_pos <= CNT_CAP) && (false_pos <= CNT_CAP)
                     && (false_neg <= CNT_CAP))
      else $error("count above saturation limit");

endmodule

`default_nettype wire
